[design/assert_macros.svh]
// Assertion macros shared by the design files.
// Each macro expands to one labeled concurrent assertion clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the enabling condition.
`define ASSERT_SAME(label, en, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the enabling condition.
`define ASSERT_NEXT(label, en, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (en) |=> (cons)) \
        else $error(msg);

`endif

[design/mts1_pkg.sv]
// Package of the SHA-1 Merkle tree builder: types, SHA-1 constants and padding.
// Used by mts1_compress and merkle_tree_sha1_builder; depends on nothing.
`timescale 1ns / 1ps

package mts1_pkg;

    localparam logic [159:0] SHA1_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    localparam logic [159:0] SHA1_EMPTY =
        160'hDA39A3EE_5E6B4B0D_3255BFEF_95601890_AFD80709;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [1:0] KIND_ROOT  = 2'd0;
    localparam logic [1:0] KIND_WHOLE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic ADDR_BLOCK_SIZE = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE, S_BCHK, S_WCHK, S_CLOSE, S_LAST, S_CSTART, S_CWAIT, S_P2,
        S_PAD, S_LVL, S_RA, S_RB, S_RC, S_ROOT, S_ROOT2, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        J_BABS, J_WABS, J_BFIN0, J_BFIN1, J_WFIN0, J_WFIN1, J_PAIR
    } t_job;

    typedef struct packed {
        logic         start;
        logic [159:0] h;
        logic [511:0] blk;
    } t_cmp_req;

    typedef struct packed {
        logic         done;
        logic [159:0] h;
    } t_cmp_rsp;

    // Builds a padded message block. Phase 0 keeps bytes below idx, puts the
    // end marker at idx and adds the bit length when it fits; phase 1 holds
    // only the bit length.
    function automatic logic [511:0] pad_block(input logic [511:0] buf_in,
                                               input logic [5:0] idx,
                                               input logic [63:0] bits,
                                               input logic phase);
        logic [511:0] res;
        res = '0;
        for (int k = 0; k < 64; k++) begin
            if (!phase) begin
                if (6'(k) < idx) begin
                    res[511 - 8 * k -: 8] = buf_in[511 - 8 * k -: 8];
                end else if (6'(k) == idx) begin
                    res[511 - 8 * k -: 8] = 8'h80;
                end
            end
        end
        if (phase || idx < 6'd56) begin
            res[63:0] = bits;
        end
        return res;
    endfunction

endpackage

[design/mts1_compress.sv]
// Iterative SHA-1 compression unit: one round per clock, 80 rounds per block.
// Depends on mts1_pkg for the request and response structs and round constants.
`timescale 1ns / 1ps

module mts1_compress (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mts1_pkg::t_cmp_req  i_req,
    output mts1_pkg::t_cmp_rsp  o_rsp
);

    logic [159:0] r_h;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_w [16];
    logic [6:0]   r_t;
    logic         r_run;
    logic         r_fin;
    logic         r_done;
    logic [159:0] r_hout;

    logic [31:0] w_f, w_k, w_tmp, w_wnew, w_x;

    always_comb begin
        if (r_t < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = mts1_pkg::K0;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = mts1_pkg::K1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = mts1_pkg::K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = mts1_pkg::K3;
        end
        w_tmp  = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
        w_x    = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_wnew = {w_x[30:0], w_x[31]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_t    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_h   <= i_req.h;
                r_a   <= i_req.h[159:128];
                r_b   <= i_req.h[127:96];
                r_c   <= i_req.h[95:64];
                r_d   <= i_req.h[63:32];
                r_e   <= i_req.h[31:0];
                for (int i = 0; i < 16; i++) begin
                    r_w[i] <= i_req.blk[511 - 32 * i -: 32];
                end
                r_t   <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_a <= w_tmp;
                r_b <= r_a;
                r_c <= {r_b[1:0], r_b[31:2]};
                r_d <= r_c;
                r_e <= r_d;
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= w_wnew;
                if (r_t == 7'd79) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end else begin
                    r_t <= r_t + 7'd1;
                end
            end else if (r_fin) begin
                r_hout <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                           r_h[63:32] + r_d, r_h[31:0] + r_e};
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.h    = r_hout;

endmodule

[design/merkle_tree_sha1_builder.sv]
// Top level of the SHA-1 Merkle tree builder: sequencer, stream contexts and node store.
// Depends on mts1_pkg, mts1_compress and assert_macros.svh.
//
// Bytes enter on the s_ channel (tdata = data byte, tlast = final byte of the stream).
// Each byte is cut into blocks of block_size bytes (APB register at address 0) and
// also into one running whole-stream SHA-1. Every block digest, up to MAX_LEAVES of them,
// becomes a leaf in the node store. After the final byte the leaves are padded with the
// empty-message digest to a power of two and reduced pairwise to the root.
// Results leave on the m_ channel: five root words, then five whole-stream words,
// tlast on the tenth; with too many blocks a single error transfer is sent instead.
// An ordinary byte passes through S_IDLE, S_BCHK, S_WCHK and S_CLOSE; each SHA-1
// compression runs in the shared 80-round unit, and a full 64-byte chunk costs two
// compressions. After the final byte the tree needs one compression per node pair,
// read first in S_RA, S_RB and S_RC, plus one S_PAD step per padding leaf written.
// The m_ channel holds its transfer while tready is low; no input is taken until the
// run's results are all delivered. Reset restores the stream contexts and sets
// block_size to 4096; the node store is not cleared.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module merkle_tree_sha1_builder #(
    parameter int MAX_LEAVES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Fields from bit 0: data_byte[7:0].
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tlast,
    output logic        o_s_tready,
    // Fields from bit 0: digest_word[31:0], word_index[34:32], zero fill.
    output logic [39:0] o_m_tdata,
    // Fields from bit 0: word_kind[1:0].
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tvalid,
    output logic        o_m_tlast,
    input  logic        i_m_tready,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int DEPTH = 2 * MAX_LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam logic [CW-1:0] MAXL = CW'(MAX_LEAVES);

    mts1_pkg::t_state r_state, n_state;
    mts1_pkg::t_job   r_job, n_job;
    mts1_pkg::t_cmp_req w_req;
    mts1_pkg::t_cmp_rsp w_rsp;

    logic [20:0]  r_bsize;
    logic [159:0] r_bchain, r_wchain, r_bdig, r_wdig, r_root, r_left, r_right;
    logic [511:0] r_bbuf, r_wbuf;
    logic [20:0]  r_bcnt;
    logic [63:0]  r_wcnt;
    logic [CW-1:0] r_leaf, r_p, r_i, r_w;
    logic         r_flag, r_err, r_last, r_need_b, r_need_w;
    logic [3:0]   r_oidx;

    logic [159:0] r_mem [DEPTH];
    logic [159:0] r_rdata;
    logic          w_we;
    logic [AW-1:0] w_wa, w_ra;
    logic [159:0]  w_wd;

    logic [20:0]  w_bs;
    logic         w_close, w_bfin2, w_wfin2, w_pair_end, w_cfg_we;
    logic [63:0]  w_bbits, w_wbits;
    logic [5:0]   w_bidx, w_widx;
    logic [2:0]   w_j;
    logic [159:0] w_dig;
    logic [31:0]  w_word;

    assign w_bs       = (r_bsize == 21'd0) ? 21'd1 : r_bsize;
    assign w_close    = (r_bcnt >= w_bs) || (r_last && r_bcnt != 21'd0);
    assign w_bidx     = r_bcnt[5:0];
    assign w_widx     = r_wcnt[5:0];
    assign w_bfin2    = w_bidx >= 6'd56;
    assign w_wfin2    = w_widx >= 6'd56;
    assign w_bbits    = {40'd0, r_bcnt, 3'b000};
    assign w_wbits    = {r_wcnt[60:0], 3'b000};
    assign w_pair_end = (r_i + CW'(1)) == (r_w >> 1);
    assign w_cfg_we   = i_psel && i_penable && i_pwrite && o_pready &&
                        i_paddr[2] == mts1_pkg::ADDR_BLOCK_SIZE;

    mts1_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts1_pkg::S_IDLE;
            r_job   <= mts1_pkg::J_BABS;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        w_req     = '0;
        w_we      = 1'b0;
        w_wa      = '0;
        w_wd      = '0;
        w_ra      = '0;
        unique case (r_state)
            mts1_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = mts1_pkg::S_BCHK;
                end
            end
            mts1_pkg::S_BCHK: begin
                if (r_need_b) begin
                    n_job   = mts1_pkg::J_BABS;
                    n_state = mts1_pkg::S_CSTART;
                end else begin
                    n_state = mts1_pkg::S_WCHK;
                end
            end
            mts1_pkg::S_WCHK: begin
                if (r_need_w) begin
                    n_job   = mts1_pkg::J_WABS;
                    n_state = mts1_pkg::S_CSTART;
                end else begin
                    n_state = mts1_pkg::S_CLOSE;
                end
            end
            mts1_pkg::S_CLOSE: begin
                if (w_close) begin
                    n_job   = mts1_pkg::J_BFIN0;
                    n_state = mts1_pkg::S_CSTART;
                end else if (r_last) begin
                    n_state = mts1_pkg::S_LAST;
                end else begin
                    n_state = mts1_pkg::S_IDLE;
                end
            end
            mts1_pkg::S_LAST: begin
                if (r_flag) begin
                    n_state = mts1_pkg::S_OUT;
                end else begin
                    n_job   = mts1_pkg::J_WFIN0;
                    n_state = mts1_pkg::S_CSTART;
                end
            end
            mts1_pkg::S_CSTART: begin
                w_req.start = 1'b1;
                unique case (r_job)
                    mts1_pkg::J_BABS: begin
                        w_req.h   = r_bchain;
                        w_req.blk = r_bbuf;
                    end
                    mts1_pkg::J_WABS: begin
                        w_req.h   = r_wchain;
                        w_req.blk = r_wbuf;
                    end
                    mts1_pkg::J_BFIN0: begin
                        w_req.h   = r_bchain;
                        w_req.blk = mts1_pkg::pad_block(r_bbuf, w_bidx, w_bbits, 1'b0);
                    end
                    mts1_pkg::J_BFIN1: begin
                        w_req.h   = r_bdig;
                        w_req.blk = mts1_pkg::pad_block(r_bbuf, w_bidx, w_bbits, 1'b1);
                    end
                    mts1_pkg::J_WFIN0: begin
                        w_req.h   = r_wchain;
                        w_req.blk = mts1_pkg::pad_block(r_wbuf, w_widx, w_wbits, 1'b0);
                    end
                    mts1_pkg::J_WFIN1: begin
                        w_req.h   = r_wdig;
                        w_req.blk = mts1_pkg::pad_block(r_wbuf, w_widx, w_wbits, 1'b1);
                    end
                    mts1_pkg::J_PAIR: begin
                        w_req.h   = mts1_pkg::SHA1_IV;
                        w_req.blk = {r_left, r_right, 32'h80000000, 128'd0, 32'h00000140};
                    end
                    default: begin
                        w_req.h = mts1_pkg::SHA1_IV;
                    end
                endcase
                n_state = mts1_pkg::S_CWAIT;
            end
            mts1_pkg::S_CWAIT: begin
                if (w_rsp.done) begin
                    unique case (r_job) inside
                        mts1_pkg::J_BABS: n_state = mts1_pkg::S_WCHK;
                        mts1_pkg::J_WABS: n_state = mts1_pkg::S_CLOSE;
                        mts1_pkg::J_BFIN0, mts1_pkg::J_BFIN1: begin
                            if (r_job == mts1_pkg::J_BFIN0 && w_bfin2) begin
                                n_job   = mts1_pkg::J_BFIN1;
                                n_state = mts1_pkg::S_CSTART;
                            end else begin
                                w_we    = r_leaf < MAXL;
                                w_wa    = AW'(r_leaf);
                                w_wd    = w_rsp.h;
                                n_state = mts1_pkg::S_CLOSE;
                            end
                        end
                        mts1_pkg::J_WFIN0: begin
                            if (w_wfin2) begin
                                n_job   = mts1_pkg::J_WFIN1;
                                n_state = mts1_pkg::S_CSTART;
                            end else begin
                                n_state = mts1_pkg::S_P2;
                            end
                        end
                        mts1_pkg::J_WFIN1: n_state = mts1_pkg::S_P2;
                        mts1_pkg::J_PAIR: begin
                            w_we    = 1'b1;
                            w_wa    = AW'(r_i);
                            w_wd    = w_rsp.h;
                            n_state = w_pair_end ? mts1_pkg::S_LVL : mts1_pkg::S_RA;
                        end
                        default: n_state = mts1_pkg::S_IDLE;
                    endcase
                end
            end
            mts1_pkg::S_P2: begin
                if (r_p >= r_leaf) begin
                    n_state = mts1_pkg::S_PAD;
                end
            end
            mts1_pkg::S_PAD: begin
                if (r_i < r_p) begin
                    w_we = 1'b1;
                    w_wa = AW'(r_i);
                    w_wd = mts1_pkg::SHA1_EMPTY;
                end else begin
                    n_state = mts1_pkg::S_LVL;
                end
            end
            mts1_pkg::S_LVL: begin
                n_state = (r_w > CW'(1)) ? mts1_pkg::S_RA : mts1_pkg::S_ROOT;
            end
            mts1_pkg::S_RA: begin
                w_ra    = AW'({r_i, 1'b0});
                n_state = mts1_pkg::S_RB;
            end
            mts1_pkg::S_RB: begin
                w_ra    = AW'({r_i, 1'b1});
                n_state = mts1_pkg::S_RC;
            end
            mts1_pkg::S_RC: begin
                n_job   = mts1_pkg::J_PAIR;
                n_state = mts1_pkg::S_CSTART;
            end
            mts1_pkg::S_ROOT: begin
                w_ra    = '0;
                n_state = mts1_pkg::S_ROOT2;
            end
            mts1_pkg::S_ROOT2: begin
                n_state = mts1_pkg::S_OUT;
            end
            mts1_pkg::S_OUT: begin
                if (i_m_tready && o_m_tlast) begin
                    n_state = mts1_pkg::S_IDLE;
                end
            end
            default: n_state = mts1_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize  <= 21'd4096;
            r_bchain <= mts1_pkg::SHA1_IV;
            r_wchain <= mts1_pkg::SHA1_IV;
            r_bcnt   <= '0;
            r_wcnt   <= '0;
            r_leaf   <= '0;
            r_flag   <= 1'b0;
            r_err    <= 1'b0;
            r_last   <= 1'b0;
            r_need_b <= 1'b0;
            r_need_w <= 1'b0;
            r_oidx   <= '0;
            r_p      <= '0;
            r_i      <= '0;
            r_w      <= '0;
        end else begin
            if (w_cfg_we) begin
                r_bsize <= i_pwdata[20:0];
            end
            case (r_state)
                mts1_pkg::S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_bbuf[{~w_bidx, 3'b111} -: 8] <= i_s_tdata;
                        r_wbuf[{~w_widx, 3'b111} -: 8] <= i_s_tdata;
                        r_need_b <= w_bidx == 6'd63;
                        r_need_w <= w_widx == 6'd63;
                        r_bcnt   <= r_bcnt + 21'd1;
                        r_wcnt   <= r_wcnt + 64'd1;
                        r_last   <= i_s_tlast;
                    end
                end
                mts1_pkg::S_CWAIT: begin
                    if (w_rsp.done) begin
                        case (r_job) inside
                            mts1_pkg::J_BABS: r_bchain <= w_rsp.h;
                            mts1_pkg::J_WABS: r_wchain <= w_rsp.h;
                            mts1_pkg::J_BFIN0, mts1_pkg::J_BFIN1: begin
                                r_bdig <= w_rsp.h;
                                if (!(r_job == mts1_pkg::J_BFIN0 && w_bfin2)) begin
                                    if (r_leaf < MAXL) begin
                                        r_leaf <= r_leaf + CW'(1);
                                    end else begin
                                        r_flag <= 1'b1;
                                    end
                                    r_bchain <= mts1_pkg::SHA1_IV;
                                    r_bcnt   <= '0;
                                end
                            end
                            mts1_pkg::J_WFIN0, mts1_pkg::J_WFIN1: begin
                                r_wdig <= w_rsp.h;
                                r_p    <= CW'(1);
                            end
                            mts1_pkg::J_PAIR: begin
                                if (w_pair_end) begin
                                    r_w <= r_w >> 1;
                                end else begin
                                    r_i <= r_i + CW'(1);
                                end
                            end
                            default: r_p <= r_p;
                        endcase
                    end
                end
                mts1_pkg::S_LAST: begin
                    r_err <= r_flag;
                    if (r_flag) begin
                        r_oidx   <= '0;
                        r_wcnt   <= '0;
                        r_wchain <= mts1_pkg::SHA1_IV;
                        r_leaf   <= '0;
                        r_flag   <= 1'b0;
                    end
                end
                mts1_pkg::S_P2: begin
                    if (r_p < r_leaf) begin
                        r_p <= r_p << 1;
                    end else begin
                        r_i <= r_leaf;
                    end
                end
                mts1_pkg::S_PAD: begin
                    if (r_i < r_p) begin
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_w <= r_p;
                    end
                end
                mts1_pkg::S_LVL: r_i <= '0;
                mts1_pkg::S_RB: r_left <= r_rdata;
                mts1_pkg::S_RC: r_right <= r_rdata;
                mts1_pkg::S_ROOT2: begin
                    r_root   <= r_rdata;
                    r_oidx   <= '0;
                    r_wcnt   <= '0;
                    r_wchain <= mts1_pkg::SHA1_IV;
                    r_leaf   <= '0;
                    r_flag   <= 1'b0;
                end
                mts1_pkg::S_OUT: begin
                    if (i_m_tready) begin
                        r_oidx <= r_oidx + 4'd1;
                    end
                end
                default: r_oidx <= r_oidx;
            endcase
        end
    end

    assign w_j   = (r_oidx < 4'd5) ? r_oidx[2:0] : 3'(r_oidx - 4'd5);
    assign w_dig = (r_oidx < 4'd5) ? r_root : r_wdig;

    always_comb begin
        case (w_j)
            3'd0:    w_word = w_dig[159:128];
            3'd1:    w_word = w_dig[127:96];
            3'd2:    w_word = w_dig[95:64];
            3'd3:    w_word = w_dig[63:32];
            default: w_word = w_dig[31:0];
        endcase
    end

    assign o_s_tready = r_state == mts1_pkg::S_IDLE;
    assign o_m_tvalid = r_state == mts1_pkg::S_OUT;
    assign o_m_tdata  = {5'd0, r_err ? 3'd0 : w_j, r_err ? 32'd0 : w_word};
    assign o_m_tuser  = r_err ? mts1_pkg::KIND_ERROR :
                        (r_oidx < 4'd5) ? mts1_pkg::KIND_ROOT : mts1_pkg::KIND_WHOLE;
    assign o_m_tlast  = r_err || r_oidx == 4'd9;
    assign o_prdata   = (i_paddr[2] == mts1_pkg::ADDR_BLOCK_SIZE) ? {11'd0, r_bsize} : 32'd0;
    assign o_pready   = 1'b1;

    `ASSERT_SAME(a_one_side, 1'b1, !(o_s_tready && o_m_tvalid), "both channels active")
    `ASSERT_SAME(a_done_wait, w_rsp.done, r_state == mts1_pkg::S_CWAIT, "stray compress done")
    `ASSERT_SAME(a_wr_range, w_we, w_wa < AW'(DEPTH - 1) || w_wa == AW'(DEPTH - 1),
                 "node store write out of range")
    `ASSERT_NEXT(a_leaf_max, r_state == mts1_pkg::S_CWAIT, r_leaf <= MAXL,
                 "leaf count above limit")

endmodule

[sim/tb_top.sv]
// Testbench of the SHA-1 Merkle tree builder: byte streams in, root and stream digests out.
// A built-in SHA-1 tree predictor checks every output transfer; depends on mts1_pkg and the RTL.
// Directed runs cover block sizes, padding, resizing mid-block and leaf padding of the tree.
`timescale 1ns / 1ps

module tb_top;

    localparam int LEAF_LIMIT = 1024;
    localparam int SETTLE_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  kind;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_s_tready;
    logic [39:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tvalid;
    logic        o_m_tlast;
    logic        i_m_tready = 1'b0;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = '0;
    logic [31:0] i_pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    merkle_tree_sha1_builder dut (.*);

    always #4 i_clk = ~i_clk;

    t_digest_word pending_words[$];
    int  mismatches = 0;
    longint cycle_count = 0;
    int  rx_hold_request = 0;
    bit  quiet_mode = 0;

    // Predictor state.
    logic [20:0]  block_size_reg;
    logic [159:0] blk_chain, whole_chain;
    logic [511:0] blk_buf, whole_buf;
    int unsigned  blk_count;
    logic [63:0]  whole_count;
    logic [159:0] leaves[0:2*LEAF_LIMIT-1];
    int unsigned  leaf_total;
    bit           overflow;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [159:0] sha1_round(input logic [159:0] h, input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
        for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        {a, b, c, d, e} = h;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = mts1_pkg::K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = mts1_pkg::K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = mts1_pkg::K2;
            end else begin
                f = b ^ c ^ d; k = mts1_pkg::K3;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    function automatic logic [159:0] sha1_digest(input logic [159:0] h,
                                                 input logic [511:0] buf_in,
                                                 input logic [63:0] count);
        logic [511:0] blk;
        int idx;
        idx = int'(count[5:0]);
        blk = '0;
        for (int i = 0; i < idx; i++) blk[511 - 8 * i -: 8] = buf_in[511 - 8 * i -: 8];
        blk[511 - 8 * idx -: 8] = 8'h80;
        if (idx >= 56) begin
            h = sha1_round(h, blk);
            blk = '0;
        end
        blk[63:0] = count << 3;
        return sha1_round(h, blk);
    endfunction

    task automatic clear_stream();
        blk_chain = mts1_pkg::SHA1_IV; blk_buf = '0; blk_count = 0;
        whole_chain = mts1_pkg::SHA1_IV; whole_buf = '0; whole_count = 0;
        leaf_total = 0; overflow = 0;
    endtask

    task automatic close_leaf();
        if (leaf_total < LEAF_LIMIT) begin
            leaves[leaf_total] = sha1_digest(blk_chain, blk_buf, 64'(blk_count));
            leaf_total++;
        end else begin
            overflow = 1;
        end
        blk_chain = mts1_pkg::SHA1_IV; blk_buf = '0; blk_count = 0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        int unsigned bs, span;
        logic [159:0] whole_digest;
        t_digest_word dw;
        bs = (block_size_reg == 21'd0) ? 32'd1 : 32'(block_size_reg);
        blk_buf[511 - 8 * (blk_count % 64) -: 8] = b;
        if (blk_count % 64 == 63) blk_chain = sha1_round(blk_chain, blk_buf);
        blk_count++;
        whole_buf[511 - 8 * whole_count[5:0] -: 8] = b;
        if (whole_count[5:0] == 6'd63) whole_chain = sha1_round(whole_chain, whole_buf);
        whole_count++;
        if (blk_count >= bs) close_leaf();
        if (!last) return;
        if (blk_count > 0) close_leaf();
        if (overflow) begin
            dw.word = '0; dw.kind = mts1_pkg::KIND_ERROR; dw.index = '0; dw.last = 1'b1;
            pending_words.push_back(dw);
            clear_stream();
            return;
        end
        whole_digest = sha1_digest(whole_chain, whole_buf, whole_count);
        span = 1;
        while (span < leaf_total) span <<= 1;
        for (int unsigned i = leaf_total; i < span; i++) leaves[i] = mts1_pkg::SHA1_EMPTY;
        for (int unsigned w = span; w > 1; w >>= 1)
            for (int unsigned i = 0; i < w / 2; i++)
                leaves[i] = sha1_digest(mts1_pkg::SHA1_IV,
                                        {leaves[2*i], leaves[2*i+1], 192'b0}, 64'd40);
        for (int j = 0; j < 5; j++) begin
            dw.word = leaves[0][159 - 32 * j -: 32]; dw.kind = mts1_pkg::KIND_ROOT;
            dw.index = 3'(j); dw.last = 1'b0;
            pending_words.push_back(dw);
        end
        for (int j = 0; j < 5; j++) begin
            dw.word = whole_digest[159 - 32 * j -: 32]; dw.kind = mts1_pkg::KIND_WHOLE;
            dw.index = 3'(j); dw.last = (j == 4);
            pending_words.push_back(dw);
        end
        clear_stream();
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus a long hold when a test asks for one.
    always @(posedge i_clk) begin
        static int stall_left = 0;
        if (rx_hold_request > 0) begin
            stall_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
            i_m_tready <= (stall_left == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transfer word=%h kind=%0d idx=%0d last=%b",
                             o_m_tdata[31:0], o_m_tuser, o_m_tdata[34:32], o_m_tlast);
            end else begin
                exp_w = pending_words.pop_front();
                if (o_m_tdata[31:0] !== exp_w.word || o_m_tuser !== exp_w.kind ||
                    o_m_tdata[34:32] !== exp_w.index || o_m_tlast !== exp_w.last ||
                    o_m_tdata[39:35] !== 5'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: expected word=%h kind=%0d idx=%0d last=%b, got %h %0d %0d %b",
                                 exp_w.word, exp_w.kind, exp_w.index, exp_w.last,
                                 o_m_tdata[31:0], o_m_tuser, o_m_tdata[34:32], o_m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_block_size(input logic [31:0] value);
        @(posedge i_clk);
        i_psel <= 1'b1; i_penable <= 1'b0; i_pwrite <= 1'b1;
        i_paddr <= 3'(4 * mts1_pkg::ADDR_BLOCK_SIZE); i_pwdata <= value;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
        block_size_reg = value[20:0];
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        i_s_tdata <= b; i_s_tlast <= last; i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        predict_byte(b, last);
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_stream(input int len, input bit closed);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom), closed && (i == len - 1));
    endtask

    task automatic drain();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_size();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();
    endtask

    task automatic test_block_sizes();
        write_block_size(32'd0);
        send_stream(5, 1);
        drain();
        write_block_size(32'd1);
        send_stream(2, 1);
        drain();
        write_block_size(32'h1F_FFFF);
        send_stream(3, 1);
        drain();
        write_block_size(32'd1048576);
        send_stream(2, 1);
        drain();
    endtask

    task automatic test_chunk_padding();
        quiet_mode = 1;
        write_block_size(32'd60);
        send_stream(60, 1);
        drain();
        quiet_mode = 0;
    endtask

    task automatic test_resize_mid_block();
        write_block_size(32'd8);
        send_stream(5, 0);
        drain();
        write_block_size(32'd3);
        send_stream(3, 1);
        drain();
    endtask

    task automatic test_tree_padding();
        write_block_size(32'd1);
        send_stream(17, 1);
        drain();
    endtask

    task automatic test_backpressure();
        write_block_size(32'd2);
        rx_hold_request = 3000;
        send_stream(3, 1);
        send_stream(6, 1);
        send_stream(4, 1);
        drain();
    endtask

    task automatic test_random_streams();
        int sent, len;
        sent = 0;
        while (sent < 50) begin
            case ($urandom_range(0, 3))
                0: write_block_size($urandom_range(0, 4));
                1: write_block_size($urandom_range(5, 70));
                2: write_block_size(32'($urandom) & 32'h1F_FFFF);
                default: ;
            endcase
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
            send_stream(len, 1);
            sent += len;
            if ($urandom_range(0, 2) == 0 || sent >= 50) drain();
            else begin
                @(posedge i_clk);
                i_s_tvalid <= 1'b0;
                wait (pending_words.size() == 0);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        block_size_reg = 21'd4096;
        clear_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_default_size();
        test_block_sizes();
        test_chunk_padding();
        test_resize_mid_block();
        test_backpressure();
        test_tree_padding();
        test_random_streams();
        drain();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/mts1_pkg.sv
design/mts1_compress.sv
design/merkle_tree_sha1_builder.sv
sim/tb_top.sv
